FILE: hw/rtl/liferle_pkg.sv
// Shared constants for the Life run-length run decoder.
package liferle_pkg;

    localparam int unsigned MAX_DIM = 4096;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned DIM_W    = 13;
    localparam int unsigned POS_W    = 12;
    localparam int unsigned CUR_W    = 16;
    localparam int unsigned OUT_DW   = 40;
    localparam int unsigned CFG_IW   = 1;

    localparam logic [DIM_W-1:0] GRID_RESET = DIM_W'(64);
    localparam logic [DIM_W-1:0] DIM_LIMIT  = DIM_W'(MAX_DIM);
    localparam logic [CUR_W-1:0] CUR_MAX    = '1;

    localparam logic [BYTE_W-1:0] CH_END   = 8'h21;  // '!'
    localparam logic [BYTE_W-1:0] CH_DEAD  = 8'h62;  // 'b'
    localparam logic [BYTE_W-1:0] CH_LIVE  = 8'h6F;  // 'o'
    localparam logic [BYTE_W-1:0] CH_EOL   = 8'h24;  // '$'
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;  // '9'

    localparam logic [CFG_IW-1:0] REG_GRID_WIDTH  = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] REG_GRID_HEIGHT = CFG_IW'(1);

endpackage

FILE: hw/rtl/life_rle_run_decoder_core.sv
// Life run-length run decoder: text bytes in, live spans and end marker out.
//
// Usage:
//   s_axis carries one pattern character per transaction (tdata = text_byte,
//   tuser = begin_req). Comments and line breaks must be stripped upstream.
//   m_axis gives one transaction per 'o' (a live span) and per '!' (end
//   marker, tlast high, all span fields zero). Digits, 'b', '$' and other
//   bytes give no output transaction.
//   The cfg channel writes grid_width (index 0) or grid_height (index 1);
//   write only while the decoder is idle. cfg is always ready.
// Flow:
//   One byte per cycle sustained while m_axis takes results. A byte sits in
//   the input register, where the cursor/count update and the span clip are
//   done, and its result lands in the output register that drives m_axis.
// Reset / stall:
//   Reset clears cursor, count and stop flag and sets the grid size to 64 x 64.
//   When m_axis stalls with a result pending, bytes that produce no output
//   still pass; a byte that produces output waits in the input register
//   and s_axis tready drops only then.
module life_rle_run_decoder_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [liferle_pkg::BYTE_W-1:0]     i_s_axis_tdata,   // [7:0] text_byte
    input  logic                               i_s_axis_tuser,   // [0] begin_req
    // master stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [liferle_pkg::OUT_DW-1:0]     o_m_axis_tdata,   // [11:0] row, [23:12] start_col,
                                                                 // [36:24] run_length, [39:37] zero
    output logic                               o_m_axis_tlast,   // end_of_pattern
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [liferle_pkg::CFG_IW-1:0]     i_cfg_index,
    input  logic [liferle_pkg::DIM_W-1:0]      i_cfg_data
);
    import liferle_pkg::*;

    logic [DIM_W-1:0]  r_grid_w;
    logic [DIM_W-1:0]  r_grid_h;

    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_begin;

    logic [CUR_W-1:0]  r_rep;
    logic              r_cnt_present;
    logic [CUR_W-1:0]  r_col;
    logic [CUR_W-1:0]  r_row;
    logic              r_stopped;

    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_row;
    logic [POS_W-1:0]  r_out_col;
    logic [DIM_W-1:0]  r_out_len;
    logic              r_out_last;

    logic [CUR_W-1:0]  n_rep;
    logic              n_cnt_present;
    logic [CUR_W-1:0]  n_col;
    logic [CUR_W-1:0]  n_row;
    logic              n_stopped;

    logic [CUR_W-1:0]  cur_rep;
    logic              cur_present;
    logic [CUR_W-1:0]  cur_col;
    logic [CUR_W-1:0]  cur_row;
    logic              cur_stopped;

    logic              is_end;
    logic              is_live;
    logic              is_dead;
    logic              is_eol;
    logic              is_digit;
    logic              emit;
    logic              s1_adv;

    logic [CUR_W-1:0]  count;
    logic [CUR_W+3:0]  rep_x10;
    logic [CUR_W:0]    col_sum;
    logic [CUR_W:0]    row_sum;
    logic [CUR_W-1:0]  col_adv;
    logic [CUR_W-1:0]  row_adv;
    logic [DIM_W-1:0]  eff_w;
    logic [DIM_W-1:0]  eff_h;
    logic              in_grid;
    logic [DIM_W-1:0]  room;
    logic [DIM_W-1:0]  span_len;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        cur_rep     = r_s1_begin ? '0 : r_rep;
        cur_present = r_s1_begin ? 1'b0 : r_cnt_present;
        cur_col     = r_s1_begin ? '0 : r_col;
        cur_row     = r_s1_begin ? '0 : r_row;
        cur_stopped = r_s1_begin ? 1'b0 : r_stopped;

        is_end   = !cur_stopped && (r_s1_byte == CH_END);
        is_live  = !cur_stopped && (r_s1_byte == CH_LIVE);
        is_dead  = !cur_stopped && (r_s1_byte == CH_DEAD);
        is_eol   = !cur_stopped && (r_s1_byte == CH_EOL);
        is_digit = !cur_stopped && (r_s1_byte >= CH_ZERO) && (r_s1_byte <= CH_NINE);
        emit     = is_end || is_live;

        count   = cur_present ? cur_rep : CUR_W'(1);
        rep_x10 = {cur_rep, 3'b000} + {2'b00, cur_rep, 1'b0}
                + (CUR_W+4)'(r_s1_byte - CH_ZERO);
        col_sum = {1'b0, cur_col} + {1'b0, count};
        row_sum = {1'b0, cur_row} + {1'b0, count};
        col_adv = col_sum[CUR_W] ? CUR_MAX : col_sum[CUR_W-1:0];
        row_adv = row_sum[CUR_W] ? CUR_MAX : row_sum[CUR_W-1:0];

        eff_w   = (r_grid_w > DIM_LIMIT) ? DIM_LIMIT : r_grid_w;
        eff_h   = (r_grid_h > DIM_LIMIT) ? DIM_LIMIT : r_grid_h;
        in_grid = (cur_row < CUR_W'(eff_h)) && (cur_col < CUR_W'(eff_w));
        room    = eff_w - cur_col[DIM_W-1:0];
        span_len = (count < CUR_W'(room)) ? count[DIM_W-1:0] : room;

        n_rep         = '0;
        n_cnt_present = 1'b0;
        n_col         = cur_col;
        n_row         = cur_row;
        n_stopped     = cur_stopped;
        if (cur_stopped) begin
            n_rep         = cur_rep;
            n_cnt_present = cur_present;
        end else if (is_end) begin
            n_stopped = 1'b1;
        end else if (is_digit) begin
            n_rep         = (rep_x10 > (CUR_W+4)'(CUR_MAX)) ? CUR_MAX : rep_x10[CUR_W-1:0];
            n_cnt_present = 1'b1;
        end else if (is_dead || is_live) begin
            n_col = col_adv;
        end else if (is_eol) begin
            n_row = row_adv;
            n_col = '0;
        end
    end

    assign s1_adv          = r_s1_valid && (!emit || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w      <= GRID_RESET;
            r_grid_h      <= GRID_RESET;
            r_s1_valid    <= 1'b0;
            r_rep         <= '0;
            r_cnt_present <= 1'b0;
            r_col         <= '0;
            r_row         <= '0;
            r_stopped     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_GRID_WIDTH) begin
                    r_grid_w <= i_cfg_data;
                end else begin
                    r_grid_h <= i_cfg_data;
                end
            end
            if (o_s_axis_tready) begin
                r_s1_valid <= i_s_axis_tvalid;
            end
            if (s1_adv) begin
                r_rep         <= n_rep;
                r_cnt_present <= n_cnt_present;
                r_col         <= n_col;
                r_row         <= n_row;
                r_stopped     <= n_stopped;
            end
            if (s1_adv && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_s1_byte  <= i_s_axis_tdata;
            r_s1_begin <= i_s_axis_tuser;
        end
        if (s1_adv && emit) begin
            r_out_last <= is_end;
            if (is_live && in_grid) begin
                r_out_row <= cur_row[POS_W-1:0];
                r_out_col <= cur_col[POS_W-1:0];
                r_out_len <= span_len;
            end else begin
                r_out_row <= '0;
                r_out_col <= '0;
                r_out_len <= '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {{(OUT_DW-2*POS_W-DIM_W){1'b0}}, r_out_len, r_out_col, r_out_row};

    a_end_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv && is_end |=> r_stopped)
        else $error("terminator did not set stop flag");

    a_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cnt_present |-> (r_rep == '0))
        else $error("repeat count held without digits");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |->
            (r_out_len == '0) && (r_out_row == '0) && (r_out_col == '0))
        else $error("end result carries span data");

    a_len_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> (r_out_len <= eff_w))
        else $error("span exceeds grid width");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |=> r_out_valid && $stable(r_out_len))
        else $error("pending result overwritten");

endmodule
